/* rtl/slpg_pkg.sv */
package slpg_pkg;

    localparam int NOW_W       = 32;
    localparam int PERIOD_W    = 12;
    localparam int CHAN_W      = 8;
    localparam int MASK_W      = 12;
    localparam int ZONE_COUNT  = 12;
    localparam int ZONE_SEARCH = (ZONE_COUNT < MASK_W) ? ZONE_COUNT : MASK_W;
    localparam int SINE_TABLE_SIZE_DEF = 256;

    // Latched error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_WIFI    = 2'd1;
    localparam logic [1:0] ERR_BROKER  = 2'd2;
    localparam logic [1:0] ERR_FAIL    = 2'd3;

    // Update phase codes
    localparam logic [1:0] OTA_IDLE     = 2'd0;
    localparam logic [1:0] OTA_DOWNLOAD = 2'd1;
    localparam logic [1:0] OTA_VERIFY   = 2'd2;

    // Boot phase codes
    localparam logic [2:0] BOOT_INIT   = 3'd0;
    localparam logic [2:0] BOOT_WIFI   = 3'd1;
    localparam logic [2:0] BOOT_TIME   = 3'd2;
    localparam logic [2:0] BOOT_BROKER = 3'd3;
    localparam logic [2:0] BOOT_READY  = 3'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } rgb_t;

    typedef enum logic [1:0] {
        KIND_FIXED   = 2'd0,
        KIND_SQUARE  = 2'd1,
        KIND_BREATHE = 2'd2
    } kind_t;

    // Quarter-wave sine, round(256 * sin(2*pi*i/256)) for i in 0..64
    function automatic logic [8:0] quarter_sine(input logic [6:0] idx);
        logic [8:0] v;
        unique case (idx)
            7'd0:  v = 9'd0;    7'd1:  v = 9'd6;    7'd2:  v = 9'd13;   7'd3:  v = 9'd19;
            7'd4:  v = 9'd25;   7'd5:  v = 9'd31;   7'd6:  v = 9'd38;   7'd7:  v = 9'd44;
            7'd8:  v = 9'd50;   7'd9:  v = 9'd56;   7'd10: v = 9'd62;   7'd11: v = 9'd68;
            7'd12: v = 9'd74;   7'd13: v = 9'd80;   7'd14: v = 9'd86;   7'd15: v = 9'd92;
            7'd16: v = 9'd98;   7'd17: v = 9'd104;  7'd18: v = 9'd109;  7'd19: v = 9'd115;
            7'd20: v = 9'd121;  7'd21: v = 9'd126;  7'd22: v = 9'd132;  7'd23: v = 9'd137;
            7'd24: v = 9'd142;  7'd25: v = 9'd147;  7'd26: v = 9'd152;  7'd27: v = 9'd157;
            7'd28: v = 9'd162;  7'd29: v = 9'd167;  7'd30: v = 9'd172;  7'd31: v = 9'd177;
            7'd32: v = 9'd181;  7'd33: v = 9'd185;  7'd34: v = 9'd190;  7'd35: v = 9'd194;
            7'd36: v = 9'd198;  7'd37: v = 9'd202;  7'd38: v = 9'd206;  7'd39: v = 9'd209;
            7'd40: v = 9'd213;  7'd41: v = 9'd216;  7'd42: v = 9'd220;  7'd43: v = 9'd223;
            7'd44: v = 9'd226;  7'd45: v = 9'd229;  7'd46: v = 9'd231;  7'd47: v = 9'd234;
            7'd48: v = 9'd237;  7'd49: v = 9'd239;  7'd50: v = 9'd241;  7'd51: v = 9'd243;
            7'd52: v = 9'd245;  7'd53: v = 9'd247;  7'd54: v = 9'd248;  7'd55: v = 9'd250;
            7'd56: v = 9'd251;  7'd57: v = 9'd252;  7'd58: v = 9'd253;  7'd59: v = 9'd254;
            7'd60: v = 9'd255;  7'd61: v = 9'd255;  7'd62: v = 9'd256;  7'd63: v = 9'd256;
            7'd64: v = 9'd256;
            default: v = 9'd256;
        endcase
        return v;
    endfunction

    function automatic rgb_t zone_palette(input logic [3:0] idx);
        rgb_t c;
        unique case (idx)
            4'd0:  c = '{8'd255, 8'd255, 8'd255};
            4'd1:  c = '{8'd255, 8'd0,   8'd0};
            4'd2:  c = '{8'd255, 8'd128, 8'd0};
            4'd3:  c = '{8'd255, 8'd255, 8'd0};
            4'd4:  c = '{8'd0,   8'd255, 8'd0};
            4'd5:  c = '{8'd0,   8'd0,   8'd255};
            4'd6:  c = '{8'd75,  8'd0,   8'd130};
            4'd7:  c = '{8'd148, 8'd0,   8'd211};
            4'd8:  c = '{8'd255, 8'd20,  8'd147};
            4'd9:  c = '{8'd0,   8'd255, 8'd255};
            4'd10: c = '{8'd128, 8'd255, 8'd0};
            4'd11: c = '{8'd255, 8'd0,   8'd255};
            default: c = '{8'd255, 8'd255, 8'd255};
        endcase
        return c;
    endfunction

    // floor(x / 255), exact for x up to 255*255
    function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] base,
                                                 input logic [CHAN_W-1:0] br);
        logic [15:0] x;
        logic [16:0] y;
        x = 16'(base) * 16'(br);
        y = 17'(x) + 17'd1 + 17'(x[15:8]);
        return y[15:8];
    endfunction

endpackage

/* rtl/slpg_divider.sv */
module slpg_divider
    import slpg_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NOW_W-1:0]             dividend,
    input  logic [PERIOD_W-1:0]          divisor,
    output logic                         done,
    output logic [PERIOD_W-1:0]          phase,
    output logic [$clog2(SINE_TABLE_SIZE)-1:0] frac
);

    localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);
    localparam int STEPS     = NOW_W + SINE_BITS;
    localparam int CNT_W     = $clog2(STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NOW_W-1:0]     dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0]  ph_reg, ph_next;
    logic [SINE_BITS-1:0] quo_reg, quo_next;
    logic [PERIOD_W:0]    trial;
    logic                 ge;

    // One restoring step: bring down the next dividend bit (zeros after the
    // integer part), subtract the divisor when it fits.
    assign trial = {rem_reg, dvd_reg[NOW_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        ph_next   = ph_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? PERIOD_W'(trial - {1'b0, divisor}) : PERIOD_W'(trial);
            dvd_next = {dvd_reg[NOW_W-2:0], 1'b0};
            quo_next = {quo_reg[SINE_BITS-2:0], ge};
            // Integer part done: remainder is the phase in the period
            if (cnt_reg == CNT_W'(NOW_W - 1))
            begin
                ph_next = rem_next;
            end
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        ph_reg  <= ph_next;
        quo_reg <= quo_next;
    end

    assign done  = done_reg;
    assign phase = ph_reg;
    assign frac  = quo_reg;

endmodule

/* rtl/status_led_pattern_generator.sv */
// Status LED pattern generator: one item per millisecond tick carries the time and the
// system status; the block answers each with one RGB color. Each item goes through the
// bit-serial restoring divider, which yields both time mod period and the sine table index,
// one bit per cycle, then the shape and scale states. Input is refused while an item is in
// work; a finished color waits in the output register and the next item may be taken
// meanwhile. SINE_TABLE_SIZE must be a power of two.
module status_led_pattern_generator
    import slpg_pkg::*;
#(
    parameter int SINE_TABLE_SIZE = SINE_TABLE_SIZE_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // now_ms[31:0], error_request[33:32], ota_phase[35:34], ota_progress[43:36],
    // boot_phase[46:44], zone_running_mask[58:47], zero[63:59]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [23:0] m_axis_tdata
);

    localparam int SINE_BITS = $clog2(SINE_TABLE_SIZE);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SHAPE = 4'b0100,
        ST_SCALE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           err_reg, err_next;
    logic [NOW_W-1:0]     start_reg, start_next;
    logic                 out_valid_reg, out_valid_next;
    rgb_t                 out_reg;

    kind_t                kind_reg, kind_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [PERIOD_W-1:0]  thr_reg, thr_next;
    logic [CHAN_W-1:0]    lo_reg, lo_next;
    logic [CHAN_W-1:0]    hi_reg, hi_next;
    logic [CHAN_W-1:0]    fbr_reg, fbr_next;
    rgb_t                 base_reg, base_next;
    logic [CHAN_W-1:0]    br_reg, br_next;

    logic [NOW_W-1:0]     now_ms;
    logic [1:0]           error_request;
    logic [1:0]           ota_phase;
    logic [7:0]           ota_progress;
    logic [2:0]           boot_phase;
    logic [MASK_W-1:0]    zone_running_mask;

    logic                 accept;
    logic [NOW_W-1:0]     since;
    logic                 fail_lit;
    logic [6:0]           prog_c;
    logic                 zone_found;
    logic [3:0]           zone_idx;

    logic                 div_done;
    logic [PERIOD_W-1:0]  div_phase;
    logic [SINE_BITS-1:0] div_frac;

    logic [SINE_BITS+7:0] k_ext;
    logic [7:0]           j;
    logic [6:0]           q_idx;
    logic [8:0]           q;
    logic [8:0]           s;
    logic [16:0]          prod;

    assign now_ms            = s_axis_tdata[31:0];
    assign error_request     = s_axis_tdata[33:32];
    assign ota_phase         = s_axis_tdata[35:34];
    assign ota_progress      = s_axis_tdata[43:36];
    assign boot_phase        = s_axis_tdata[46:44];
    assign zone_running_mask = s_axis_tdata[58:47];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Latch a changed error request; update failure sticks
    always_comb
    begin
        err_next   = err_reg;
        start_next = start_reg;
        if (accept && err_reg != ERR_FAIL && error_request != err_reg)
        begin
            err_next   = error_request;
            start_next = now_ms;
        end
    end

    assign since    = now_ms - start_next;
    assign fail_lit = (since < 32'd250)
                   || (since >= 32'd500 && since < 32'd750)
                   || (since >= 32'd1000 && since < 32'd1250);
    assign prog_c   = (ota_progress > 8'd100) ? 7'd100 : ota_progress[6:0];

    // Lowest running zone
    always_comb
    begin
        zone_found = 1'b0;
        zone_idx   = '0;
        for (int i = ZONE_SEARCH - 1; i >= 0; i--)
        begin
            if (zone_running_mask[i])
            begin
                zone_found = 1'b1;
                zone_idx   = 4'(i);
            end
        end
    end

    // Pick the pattern by priority. A channel that shows the brightness itself
    // uses base 255, since scaling by 255 leaves it unchanged.
    always_comb
    begin
        kind_next   = KIND_FIXED;
        period_next = PERIOD_W'(1000);
        thr_next    = '0;
        lo_next     = '0;
        hi_next     = '0;
        fbr_next    = '0;
        base_next   = '{8'd0, 8'd0, 8'd0};
        priority if (err_next == ERR_FAIL)
        begin
            base_next = '{8'd255, 8'd0, 8'd0};
            fbr_next  = fail_lit ? 8'd255 : 8'd0;
        end
        else if (ota_phase == OTA_DOWNLOAD)
        begin
            kind_next   = KIND_BREATHE;
            period_next = PERIOD_W'(2500) - PERIOD_W'(prog_c) * PERIOD_W'(17);
            lo_next     = 8'd20;
            hi_next     = 8'd220;
            base_next   = '{8'd255, 8'd128, 8'd0};
        end
        else if (ota_phase == OTA_VERIFY)
        begin
            kind_next   = KIND_SQUARE;
            period_next = PERIOD_W'(200);
            thr_next    = PERIOD_W'(100);
            fbr_next    = 8'd255;
            base_next   = '{8'd200, 8'd200, 8'd0};
        end
        else if (err_next == ERR_WIFI || err_next == ERR_BROKER)
        begin
            kind_next   = KIND_SQUARE;
            period_next = PERIOD_W'(1000);
            thr_next    = PERIOD_W'(300);
            fbr_next    = 8'd255;
            base_next   = '{8'd180, 8'd0, 8'd0};
        end
        else if (zone_found)
        begin
            kind_next   = KIND_BREATHE;
            period_next = PERIOD_W'(2000);
            lo_next     = 8'd30;
            hi_next     = 8'd130;
            base_next   = zone_palette(zone_idx);
        end
        else
        begin
            unique case (boot_phase)
                BOOT_INIT:
                begin
                    kind_next   = KIND_BREATHE;
                    period_next = PERIOD_W'(1500);
                    lo_next     = 8'd10;
                    hi_next     = 8'd80;
                    base_next   = '{8'd255, 8'd255, 8'd255};
                end
                BOOT_WIFI:
                begin
                    kind_next   = KIND_BREATHE;
                    period_next = PERIOD_W'(1500);
                    lo_next     = 8'd20;
                    hi_next     = 8'd200;
                    base_next   = '{8'd0, 8'd120, 8'd255};
                end
                BOOT_TIME:
                begin
                    kind_next   = KIND_BREATHE;
                    period_next = PERIOD_W'(1000);
                    lo_next     = 8'd20;
                    hi_next     = 8'd200;
                    base_next   = '{8'd0, 8'd255, 8'd255};
                end
                BOOT_BROKER:
                begin
                    kind_next   = KIND_BREATHE;
                    period_next = PERIOD_W'(1500);
                    lo_next     = 8'd20;
                    hi_next     = 8'd200;
                    base_next   = '{8'd25, 8'd60, 8'd200};
                end
                BOOT_READY:
                begin
                    kind_next   = KIND_SQUARE;
                    period_next = PERIOD_W'(2000);
                    thr_next    = PERIOD_W'(100);
                    fbr_next    = 8'd40;
                    base_next   = '{8'd25, 8'd60, 8'd200};
                end
                default:
                begin
                    fbr_next = 8'd0;
                end
            endcase
        end
    end

    slpg_divider #(
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (now_ms),
        .divisor  (period_reg),
        .done     (div_done),
        .phase    (div_phase),
        .frac     (div_frac)
    );

    // Sine index from the table position, then the raised sine in 0..256
    assign k_ext = {{8{1'b0}}, div_frac};
    assign j     = 8'((k_ext << 8) >> SINE_BITS);

    always_comb
    begin
        priority if (j < 8'd64)
        begin
            q_idx = j[6:0];
        end
        else if (j < 8'd128)
        begin
            q_idx = 7'(8'd128 - j);
        end
        else if (j < 8'd192)
        begin
            q_idx = 7'(j - 8'd128);
        end
        else
        begin
            q_idx = 7'(9'd256 - 9'(j));
        end
    end

    assign q    = quarter_sine(q_idx);
    assign s    = (j < 8'd128) ? 9'((10'd256 + 10'(q)) >> 1) : 9'((10'd256 - 10'(q)) >> 1);
    assign prod = 17'(s) * 17'(hi_reg - lo_reg);

    always_comb
    begin
        unique case (kind_reg)
            KIND_BREATHE: br_next = lo_reg + prod[15:8];
            KIND_SQUARE:  br_next = (div_phase < thr_reg) ? fbr_reg : 8'd0;
            default:      br_next = fbr_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SHAPE;
                end
            end
            ST_SHAPE:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            err_reg       <= ERR_NONE;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind_next;
            period_reg <= period_next;
            thr_reg    <= thr_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            fbr_reg    <= fbr_next;
            base_reg   <= base_next;
        end
        if (state_reg == ST_SHAPE)
        begin
            br_reg <= br_next;
        end
        if (state_reg == ST_SCALE && (!out_valid_reg || m_axis_tready))
        begin
            out_reg.r <= scale8(base_reg.r, br_reg);
            out_reg.g <= scale8(base_reg.g, br_reg);
            out_reg.b <= scale8(base_reg.b, br_reg);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.b, out_reg.g, out_reg.r};

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_fail_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg == ERR_FAIL |=> err_reg == ERR_FAIL)
        else $error("update failure was cleared");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCALE && out_valid_reg && !m_axis_tready |=> state_reg == ST_SCALE)
        else $error("pending color overwritten");

    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> period_reg != '0)
        else $error("zero period in divider");

endmodule

/* bench/status_led_pattern_generator_test.sv */
module status_led_pattern_generator_test;
    import slpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Failure starts just below the 32-bit wrap so the blink sequence crosses it.
    localparam logic [31:0] FAIL_T0 = 32'hFFFF_FF00;

    localparam int unsigned SINE_QTR [65] = '{
        0, 6, 13, 19, 25, 31, 38, 44, 50, 56, 62, 68, 74, 80, 86, 92,
        98, 104, 109, 115, 121, 126, 132, 137, 142, 147, 152, 157, 162, 167, 172, 177,
        181, 185, 190, 194, 198, 202, 206, 209, 213, 216, 220, 223, 226, 229, 231, 234,
        237, 239, 241, 243, 245, 247, 248, 250, 251, 252, 253, 254, 255, 255, 256, 256,
        256
    };

    localparam int unsigned PALETTE [12][3] = '{
        '{255, 255, 255}, '{255, 0, 0},   '{255, 128, 0},   '{255, 255, 0},
        '{0, 255, 0},     '{0, 0, 255},   '{75, 0, 130},    '{148, 0, 211},
        '{255, 20, 147},  '{0, 255, 255}, '{128, 255, 0},   '{255, 0, 255}
    };

    // Last field in the low bits of tdata.
    typedef struct packed {
        logic [11:0] zone_mask;
        logic [2:0]  boot;
        logic [7:0]  progress;
        logic [1:0]  ota;
        logic [1:0]  err_req;
        logic [31:0] now_ms;
    } tick_t;

    class color_tracker;
        rgb_t        colors_due[$];
        logic [1:0]  err_held;
        logic [31:0] err_since;
        int          failures;

        function new();
            err_held  = ERR_NONE;
            err_since = '0;
            failures  = 0;
        endfunction

        function int unsigned shade(int unsigned base, int unsigned br);
            return (base * br) / 255;
        endfunction

        function int unsigned breathe(logic [31:0] now_ms, int unsigned period,
                                      int unsigned lo, int unsigned hi);
            int unsigned ph;
            int unsigned j;
            int unsigned q;
            int unsigned s;
            ph = now_ms % period;
            j  = ((ph * SINE_TABLE_SIZE_DEF) / period) & 255;
            if (j < 64)
                q = SINE_QTR[j];
            else if (j < 128)
                q = SINE_QTR[128 - j];
            else if (j < 192)
                q = SINE_QTR[j - 128];
            else
                q = SINE_QTR[256 - j];
            s = (j < 128) ? ((256 + q) >> 1) : ((256 - q) >> 1);
            return lo + ((s * (hi - lo)) >> 8);
        endfunction

        function rgb_t predict_color(tick_t t);
            rgb_t        c;
            int unsigned br;
            int unsigned zone;
            int unsigned prog;
            logic [31:0] since;
            c    = '0;
            zone = 0;
            // Update failure sticks once latched.
            if (t.err_req != err_held && err_held != ERR_FAIL) begin
                err_held  = t.err_req;
                err_since = t.now_ms;
            end
            for (int i = 0; i < ZONE_SEARCH; i++)
                if (zone == 0 && t.zone_mask[i])
                    zone = i + 1;

            if (err_held == ERR_FAIL) begin
                since = t.now_ms - err_since;
                if (since < 1500 && ((since / 250) % 2) == 0)
                    c.r = 8'd255;
            end
            else if (t.ota == OTA_DOWNLOAD) begin
                prog = (t.progress > 100) ? 100 : t.progress;
                br   = breathe(t.now_ms, 2500 - 17 * prog, 20, 220);
                c.r  = 8'(shade(255, br));
                c.g  = 8'(shade(128, br));
            end
            else if (t.ota == OTA_VERIFY) begin
                if ((t.now_ms % 200) < 100) begin
                    c.r = 8'd200;
                    c.g = 8'd200;
                end
            end
            else if (err_held == ERR_WIFI || err_held == ERR_BROKER) begin
                if ((t.now_ms % 1000) < 300)
                    c.r = 8'd180;
            end
            else if (zone != 0) begin
                br  = breathe(t.now_ms, 2000, 30, 130);
                c.r = 8'(shade(PALETTE[zone - 1][0], br));
                c.g = 8'(shade(PALETTE[zone - 1][1], br));
                c.b = 8'(shade(PALETTE[zone - 1][2], br));
            end
            else begin
                case (t.boot)
                    BOOT_INIT: begin
                        br = breathe(t.now_ms, 1500, 10, 80);
                        c  = '{8'(br), 8'(br), 8'(br)};
                    end
                    BOOT_WIFI: begin
                        br  = breathe(t.now_ms, 1500, 20, 200);
                        c.g = 8'(shade(120, br));
                        c.b = 8'(shade(255, br));
                    end
                    BOOT_TIME: begin
                        br  = breathe(t.now_ms, 1000, 20, 200);
                        c.g = 8'(br);
                        c.b = 8'(br);
                    end
                    BOOT_BROKER: begin
                        br  = breathe(t.now_ms, 1500, 20, 200);
                        c.r = 8'(shade(25, br));
                        c.g = 8'(shade(60, br));
                        c.b = 8'(shade(200, br));
                    end
                    BOOT_READY: begin
                        if ((t.now_ms % 2000) < 100) begin
                            c.r = 8'(shade(25, 40));
                            c.g = 8'(shade(60, 40));
                            c.b = 8'(shade(200, 40));
                        end
                    end
                    default: c = '0;
                endcase
            end
            return c;
        endfunction

        function void note_tick(tick_t t);
            colors_due.push_back(predict_color(t));
        endfunction

        function void check_color(logic [23:0] data);
            rgb_t want;
            if (colors_due.size() == 0) begin
                $error("color %h arrived with no tick pending", data);
                failures++;
                return;
            end
            want = colors_due.pop_front();
            if (data[7:0] !== want.r) begin
                $error("red mismatch: expected %0d, got %0d", want.r, data[7:0]);
                failures++;
            end
            if (data[15:8] !== want.g) begin
                $error("green mismatch: expected %0d, got %0d", want.g, data[15:8]);
                failures++;
            end
            if (data[23:16] !== want.b) begin
                $error("blue mismatch: expected %0d, got %0d", want.b, data[23:16]);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    color_tracker tracker;
    tick_t        ticks_to_send[$];

    status_led_pattern_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void add_tick(logic [31:0] now_ms, logic [1:0] err_req,
                                     logic [1:0] ota, logic [7:0] progress,
                                     logic [2:0] boot, logic [11:0] zone_mask);
        tick_t t;
        t.now_ms    = now_ms;
        t.err_req   = err_req;
        t.ota       = ota;
        t.progress  = progress;
        t.boot      = boot;
        t.zone_mask = zone_mask;
        ticks_to_send.push_back(t);
    endfunction

    // Unless failing, mostly walk time forward in small steps so the breathe curves are traced;
    // jump at random now and then. When failing, times mostly fall just after FAIL_T0.
    function automatic void plan_random_ticks(int count, logic [31:0] start, bit failing);
        logic [31:0] now_ms;
        logic [1:0]  err_req;
        logic [1:0]  ota;
        logic [7:0]  progress;
        logic [2:0]  boot;
        logic [11:0] zone_mask;
        int          pick;
        now_ms  = start;
        err_req = ERR_NONE;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (failing)
                now_ms = (pick < 80) ? FAIL_T0 + $urandom_range(0, 2000) : $urandom;
            else if (pick < 70)
                now_ms = now_ms + $urandom_range(1, 60);
            else if (pick < 75)
                now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
            else
                now_ms = $urandom;

            if (failing)
                err_req = 2'($urandom_range(0, 3));
            else if ($urandom_range(0, 19) == 0)
                err_req = 2'($urandom_range(0, 2));

            pick = $urandom_range(0, 99);
            ota = (pick < 55) ? OTA_IDLE : (pick < 75) ? OTA_DOWNLOAD :
                  (pick < 90) ? OTA_VERIFY : 2'd3;
            progress = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 100));
            boot = $urandom_range(0, 9) < 8 ? 3'($urandom_range(0, 4))
                                            : 3'($urandom_range(5, 7));

            pick = $urandom_range(0, 9);
            if (pick < 5)
                zone_mask = '0;
            else if (pick < 7)
                zone_mask = 12'd1 << $urandom_range(0, 11);
            else
                zone_mask = 12'($urandom_range(0, 4095));

            add_tick(now_ms, err_req, ota, progress, boot, zone_mask);
        end
    endfunction

    task automatic send_ticks();
        tick_t t;
        int    burst;
        int    gap;
        burst = $urandom_range(1, 16);
        while (ticks_to_send.size() > 0) begin
            t = ticks_to_send.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {5'd0, t};
            do
                @(posedge clk);
            while (!s_axis_tready);
            tracker.note_tick(t);
            burst--;
            if (ticks_to_send.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (burst == 0) begin
                burst = $urandom_range(1, 16);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // Receiver: segments of always-ready, random and sparse ready, plus two long
    // hold-offs that back the block up into its input.
    initial
    begin : sink
        int cycle;
        int mode;
        int seg;
        cycle = 0;
        mode  = 0;
        seg   = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            cycle++;
            if (seg == 0) begin
                mode = $urandom_range(0, 3);
                seg  = $urandom_range(20, 300);
            end
            seg--;
            if ((cycle >= 4000 && cycle < 4600) || (cycle >= 20000 && cycle < 20300))
                m_axis_tready <= 1'b0;
            else
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 9) == 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_color(m_axis_tdata);
    end

    initial
    begin : stimulus
        tracker = new();

        // boot phases with no zone, including unknown phases and unknown update phase
        add_tick(32'd0,          ERR_NONE, OTA_IDLE, 8'd0,   BOOT_INIT,   12'h000);
        add_tick(32'hFFFF_FFFF,  ERR_NONE, OTA_IDLE, 8'd255, BOOT_WIFI,   12'h000);
        add_tick(32'd250,        ERR_NONE, OTA_IDLE, 8'd0,   BOOT_TIME,   12'h000);
        add_tick(32'd1125,       ERR_NONE, OTA_IDLE, 8'd0,   BOOT_BROKER, 12'h000);
        add_tick(32'd4000,       ERR_NONE, OTA_IDLE, 8'd0,   BOOT_READY,  12'h000);
        add_tick(32'd2100,       ERR_NONE, OTA_IDLE, 8'd0,   BOOT_READY,  12'h000);
        add_tick(32'd777,        ERR_NONE, OTA_IDLE, 8'd0,   3'd5,        12'h000);
        add_tick(32'd778,        ERR_NONE, 2'd3,     8'd50,  3'd7,        12'h000);
        add_tick(32'd779,        ERR_NONE, 2'd3,     8'd50,  BOOT_WIFI,   12'h000);
        // downloading: no progress, full, clamped above 100; then verifying
        add_tick(32'd1234,       ERR_NONE, OTA_DOWNLOAD, 8'd0,   BOOT_READY, 12'h000);
        add_tick(32'd1234,       ERR_NONE, OTA_DOWNLOAD, 8'd100, BOOT_READY, 12'h000);
        add_tick(32'd1234,       ERR_NONE, OTA_DOWNLOAD, 8'd255, BOOT_READY, 12'hFFF);
        add_tick(32'd50,         ERR_NONE, OTA_VERIFY,   8'd0,   BOOT_INIT,  12'h000);
        add_tick(32'd150,        ERR_NONE, OTA_VERIFY,   8'd0,   BOOT_INIT,  12'h001);
        // network errors, then cleared
        add_tick(32'd10010,      ERR_WIFI,   OTA_IDLE, 8'd0, BOOT_WIFI,   12'h001);
        add_tick(32'd10350,      ERR_BROKER, OTA_IDLE, 8'd0, BOOT_BROKER, 12'h000);
        add_tick(32'd10299,      ERR_BROKER, OTA_IDLE, 8'd0, BOOT_BROKER, 12'h000);
        add_tick(32'd10500,      ERR_NONE,   OTA_IDLE, 8'd0, BOOT_READY,  12'h000);
        // zones: lowest, highest only, all, a pair
        add_tick(32'd500,        ERR_NONE, OTA_IDLE, 8'd0, BOOT_INIT, 12'h001);
        add_tick(32'd1500,       ERR_NONE, OTA_IDLE, 8'd0, BOOT_INIT, 12'h800);
        add_tick(32'd1999,       ERR_NONE, OTA_IDLE, 8'd0, BOOT_READY, 12'hFFF);
        add_tick(32'd3333,       ERR_NONE, OTA_IDLE, 8'd0, BOOT_READY, 12'h440);

        plan_random_ticks(610, 32'd20000, 1'b0);

        // update failure: blink edges across the time wrap, then dark; never cleared
        add_tick(FAIL_T0,             ERR_FAIL, OTA_IDLE,     8'd0, BOOT_INIT, 12'h000);
        add_tick(FAIL_T0 + 32'd249,   ERR_NONE, OTA_DOWNLOAD, 8'd9, BOOT_INIT, 12'h000);
        add_tick(FAIL_T0 + 32'd250,   ERR_WIFI, OTA_IDLE,     8'd0, BOOT_INIT, 12'h001);
        add_tick(FAIL_T0 + 32'd500,   ERR_NONE, OTA_VERIFY,   8'd0, BOOT_INIT, 12'h000);
        add_tick(FAIL_T0 + 32'd1499,  ERR_NONE, OTA_IDLE,     8'd0, BOOT_INIT, 12'h000);
        add_tick(FAIL_T0 + 32'd1500,  ERR_FAIL, OTA_IDLE,     8'd0, BOOT_INIT, 12'h000);
        add_tick(FAIL_T0 + 32'd5000,  ERR_NONE, OTA_IDLE,     8'd0, BOOT_READY, 12'h000);

        plan_random_ticks(40, FAIL_T0, 1'b1);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_ticks();

        while (tracker.colors_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (tracker.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/slpg_pkg.sv
rtl/slpg_divider.sv
rtl/status_led_pattern_generator.sv
bench/status_led_pattern_generator_test.sv
